@@ design/priority_bandwidth_quota_allocator_macros.svh @@
// Assertion macros for the checker file of the quota allocator.
`ifndef PRIORITY_BANDWIDTH_QUOTA_ALLOCATOR_MACROS_SVH
`define PRIORITY_BANDWIDTH_QUOTA_ALLOCATOR_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define PBQA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PBQA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/pbqa_pkg.sv @@
// Types, constants and helper functions of the quota allocator.
package pbqa_pkg;

  localparam int MAX_CLIENTS_DEF = 16;
  localparam int IDX_W           = 6;
  localparam int CFG_IDX_W       = 1;

  localparam logic [15:0] MIN_RESERVE_RST = 16'd32;

  localparam logic [2:0] MODE_ATTACH = 3'd0;
  localparam logic [2:0] MODE_DETACH = 3'd1;
  localparam logic [2:0] MODE_PRIO   = 3'd2;
  localparam logic [2:0] MODE_USAGE  = 3'd3;
  localparam logic [2:0] MODE_TICK   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_QUOTA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RESERVE = 1'd1;

  // floor(x / 10) == (x * RECIP_TEN) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef enum logic [3:0] {
    OP_HOLD     = 4'd0,
    OP_ATTACH   = 4'd1,
    OP_DETACH   = 4'd2,
    OP_PRIO     = 4'd3,
    OP_USAGE    = 4'd4,
    OP_SORT_EVN = 4'd5,
    OP_SORT_ODD = 4'd6,
    OP_ROTATE   = 4'd7,
    OP_ADD      = 4'd8
  } cell_op_e;

  typedef struct packed {
    logic             active;
    logic [7:0]       prio;
    logic [IDX_W-1:0] idx;
    logic [31:0]      used;
    logic [31:0]      resv;
    logic             thr;
  } rec_t;

  typedef struct packed {
    cell_op_e    op;
    logic [3:0]  slot;
    logic [7:0]  prio;
    logic [31:0] amount;
    logic [31:0] share;
  } cell_ctrl_t;

  // Visiting order: active first, then higher priority, then lower slot.
  function automatic logic goes_first(rec_t a, rec_t b);
    logic same_act;
    same_act = (a.active == b.active);
    return (a.active & ~b.active) |
           (same_act & ((a.prio > b.prio) | ((a.prio == b.prio) & (a.idx < b.idx))));
  endfunction

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ design/priority_bandwidth_quota_allocator.sv @@
// Top level of the priority bandwidth quota allocator.
//
// Usage: a request is taken on a rising edge with start high and busy low.
// mode_i selects attach, detach, set priority, add usage or tick; slot_i,
// prio_i, amount_i and now_seconds_i carry the operands. Table updates leave
// busy low. A tick with a new second raises busy and:
//   sorts the client chain by odd-even exchange,
//   walks every cell (an active cell first waits for the multiply, then updates),
//   divides leftover quota by the client count (only if quota is left),
//   then adds the share to every active client, and emits one result per active
//   client on consecutive cycles with strobe_o, last_o on the final one.
// Most of a tick goes to the sequential walk through the chain head and the
// bit-serial divider.
// Results last one cycle each and cannot be stalled. Reset clears all client
// records, sets min_reserve to 32, the quota limit and the last second to 0.
// Configuration: cfg_valid_i with cfg_index_i / cfg_data_i; ready only while
// busy is low and no request is offered on start.
module priority_bandwidth_quota_allocator import pbqa_pkg::*; #(
  parameter int MAX_CLIENTS = MAX_CLIENTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           mode_i,
  input  logic [3:0]           slot_i,
  input  logic [7:0]           prio_i,
  input  logic [31:0]          amount_i,
  input  logic [31:0]          now_seconds_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 strobe_o,
  output logic [3:0]           client_slot_o,
  output logic [31:0]          reserved_bytes_o,
  output logic                 throttled_o,
  output logic                 last_o
);

  localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAX_CLIENTS - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SORT = 6'b000010,
    ST_WALK = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [31:0]      quota_cap_q;
  logic [15:0]      min_reserve_q;
  logic [31:0]      last_sec_q;
  logic [31:0]      quota_q, quota_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] emit_q, emit_d;
  logic             mul_q, mul_d;
  logic [63:0]      prod_q;
  logic [31:0]      share_q;

  logic             out_vld_q, out_vld_d;
  logic [3:0]       out_slot_q;
  logic [31:0]      out_resv_q;
  logic             out_thr_q;
  logic             out_last_q;

  logic             accept;
  cell_ctrl_t       ctrl;
  rec_t             recs [MAX_CLIENTS];
  rec_t             head, wrap, upd;

  logic             div_start, div_done;
  logic [31:0]      div_quot;

  logic [28:0]      div10;
  logic [32:0]      grant_raw;
  logic [31:0]      grant_cap, grant_fin, quota_nx;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  // hold config writes off while a tick runs or a request is offered
  assign cfg_ready_o = !busy && !start;
  assign head        = recs[0];

  // cell chain: cell i sees i-1 (cell 0 itself) on the left and i+1 (or the wrap record) on the right
  for (genvar gi = 0; gi < MAX_CLIENTS; gi++) begin : g_cell
    rec_t left_w, right_w;
    if (gi == 0) begin : g_l0
      assign left_w = recs[0];
    end else begin : g_ln
      assign left_w = recs[gi-1];
    end
    if (gi == MAX_CLIENTS - 1) begin : g_rl
      assign right_w = wrap;
    end else begin : g_rn
      assign right_w = recs[gi+1];
    end
    pbqa_cell #(
      .CELL  (gi),
      .FIRST (gi == 0),
      .LAST  (gi == MAX_CLIENTS - 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .rec_o   (recs[gi])
    );
  end

  // grant for the head client; prod_q holds used * RECIP_TEN from the cycle before
  always_comb begin
    div10 = prod_q[63:RECIP_SHIFT];
    if (quota_q == '0) begin
      grant_raw = '0;
    end else if (head.used == head.resv) begin
      grant_raw = {1'b0, head.used} + {2'b0, head.used[31:1]};
    end else begin
      grant_raw = {1'b0, head.used} + {4'b0, div10};
    end
    grant_cap = (grant_raw > {1'b0, quota_q}) ? quota_q : grant_raw[31:0];
    grant_fin = (grant_cap < {16'b0, min_reserve_q}) ? {16'b0, min_reserve_q} : grant_cap;
    quota_nx  = (grant_fin < quota_q) ? quota_q - grant_fin : '0;
    upd       = head;
    upd.used  = '0;
    upd.resv  = grant_fin;
    upd.thr   = (quota_nx == '0);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    quota_d     = quota_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    emit_d      = emit_q;
    mul_d       = mul_q;
    out_vld_d   = 1'b0;
    div_start   = 1'b0;
    wrap        = head;
    ctrl        = '0;
    ctrl.op     = OP_HOLD;
    ctrl.slot   = slot_i;
    ctrl.prio   = prio_i;
    ctrl.amount = amount_i;
    ctrl.share  = share_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_ATTACH: ctrl.op = OP_ATTACH;
            MODE_DETACH: ctrl.op = OP_DETACH;
            MODE_PRIO:   ctrl.op = OP_PRIO;
            MODE_USAGE:  ctrl.op = OP_USAGE;
            MODE_TICK: begin
              if (now_seconds_i != last_sec_q) begin
                quota_d = quota_cap_q;
                step_d  = '0;
                cnt_d   = '0;
                mul_d   = 1'b0;
                state_d = ST_SORT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SORT: begin
        ctrl.op = step_q[0] ? OP_SORT_ODD : OP_SORT_EVN;
        step_d  = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (head.active && !mul_q) begin
          // wait for the registered reciprocal product
          mul_d = 1'b1;
        end else begin
          ctrl.op = OP_ROTATE;
          step_d  = step_q + 1'b1;
          if (head.active) begin
            wrap    = upd;
            quota_d = quota_nx;
            cnt_d   = cnt_q + 1'b1;
            mul_d   = 1'b0;
          end
          if (step_q == LAST_STEP) begin
            emit_d = '0;
            if (cnt_d == '0) begin
              state_d = ST_IDLE;
            end else if (quota_d != '0) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_ADD;
      end
      ST_ADD: begin
        ctrl.op = OP_ADD;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // active clients sit at the front of the chain in visiting order
        ctrl.op   = OP_ROTATE;
        out_vld_d = 1'b1;
        emit_d    = emit_q + 1'b1;
        if (emit_q == cnt_q - 1'b1) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  pbqa_div #(.CNT_W(CNT_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (quota_d),
    .divisor_i  (cnt_d),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      quota_cap_q   <= '0;
      min_reserve_q <= MIN_RESERVE_RST;
      last_sec_q    <= '0;
      quota_q       <= '0;
      step_q        <= '0;
      cnt_q         <= '0;
      emit_q        <= '0;
      mul_q         <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      quota_q   <= quota_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      emit_q    <= emit_d;
      mul_q     <= mul_d;
      out_vld_q <= out_vld_d;
      if (accept && mode_i == MODE_TICK) last_sec_q <= now_seconds_i;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_TOTAL_QUOTA: quota_cap_q   <= cfg_data_i;
          CFG_MIN_RESERVE: min_reserve_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers: product, share and result payload
  always_ff @(posedge clk_i) begin
    prod_q <= head.used * RECIP_TEN;
    if (div_done) share_q <= div_quot;
    if (out_vld_d) begin
      out_slot_q <= head.idx[3:0];
      out_resv_q <= head.resv;
      out_thr_q  <= head.thr;
      out_last_q <= (emit_q == cnt_q - 1'b1);
    end
  end

  assign strobe_o         = out_vld_q;
  assign client_slot_o    = out_slot_q;
  assign reserved_bytes_o = out_resv_q;
  assign throttled_o      = out_thr_q;
  assign last_o           = out_last_q;

endmodule

@@ design/pbqa_cell.sv @@
// One client cell of the allocator chain: holds a client record and swaps or shifts it.
module pbqa_cell import pbqa_pkg::*; #(
  parameter int CELL  = 0,
  parameter bit FIRST = 1'b0,
  parameter bit LAST  = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       left_i,
  input  rec_t       right_i,
  output rec_t       rec_o
);

  localparam bit EVEN = (CELL % 2) == 0;
  localparam rec_t REC_RST = '{active: 1'b0, prio: '0, idx: IDX_W'(CELL),
                               used: '0, resv: '0, thr: 1'b0};

  rec_t rec_q, rec_d;
  logic match;
  logic is_left;

  assign match = (rec_q.idx == IDX_W'(ctrl_i.slot));

  always_comb begin
    rec_d   = rec_q;
    is_left = (ctrl_i.op == OP_SORT_EVN) ? EVEN : !EVEN;
    unique case (ctrl_i.op) inside
      OP_ATTACH: begin
        if (match) begin
          rec_d.active = 1'b1;
          rec_d.prio   = ctrl_i.prio;
          rec_d.used   = '0;
          rec_d.resv   = '0;
        end
      end
      OP_DETACH: begin
        if (match) rec_d.active = 1'b0;
      end
      OP_PRIO: begin
        if (match) rec_d.prio = ctrl_i.prio;
      end
      OP_USAGE: begin
        if (match) rec_d.used = sat_add32(rec_q.used, ctrl_i.amount);
      end
      OP_SORT_EVN, OP_SORT_ODD: begin
        // left member takes the earlier of the pair, right member the later
        if (is_left) begin
          if (!LAST && goes_first(right_i, rec_q)) rec_d = right_i;
        end else begin
          if (!FIRST && goes_first(rec_q, left_i)) rec_d = left_i;
        end
      end
      OP_ROTATE: rec_d = right_i;
      OP_ADD: begin
        if (rec_q.active) rec_d.resv = sat_add32(rec_q.resv, ctrl_i.share);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= REC_RST;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

@@ design/pbqa_div.sv @@
// Restoring divider, one quotient bit per cycle, for the leftover quota split.
module pbqa_div import pbqa_pkg::*; #(
  parameter int CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o
);

  logic             run_q;
  logic             done_q;
  logic [4:0]       bit_q;
  logic [31:0]      dq_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] dvs_q;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_nx;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, dq_q[31]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        bit_q <= 5'd31;
      end else if (run_q) begin
        bit_q <= bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      dq_q  <= {dq_q[30:0], ge};
      rem_q <= rem_nx[CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

@@ design/pbqa_chk.sv @@
// Port-level checker for the quota allocator, bound to the top level.
`include "priority_bandwidth_quota_allocator_macros.svh"

module pbqa_chk import pbqa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic strobe_o,
  input logic last_o
);

  `PBQA_ASSERT_NEXT(a_idle_no_result, clk_i, rst_ni, !busy, !strobe_o, "result while idle")
  `PBQA_ASSERT_NEXT(a_burst_dense, clk_i, rst_ni, strobe_o && !last_o, strobe_o, "gap in results")
  `PBQA_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, strobe_o && last_o, !strobe_o, "result after last")
  `PBQA_ASSERT_NOW(a_mid_busy, clk_i, rst_ni, strobe_o && !last_o, busy, "idle mid burst")

endmodule

bind priority_bandwidth_quota_allocator pbqa_chk u_pbqa_chk (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the priority bandwidth quota allocator.
`timescale 1ns / 1ps

module tb;
  import pbqa_pkg::*;

  localparam int          NUM_SLOTS   = 16;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 150;
  localparam logic [2:0]  MODE_BAD_LO = MODE_TICK + 3'd1;

  // One client result as the block should report it.
  typedef struct {
    logic [3:0]  slot;
    logic [31:0] resv;
    logic        thr;
    logic        last;
  } grant_t;

  // Scoreboard: mirrors the client table and holds the pending grant reports.
  class quota_board;
    bit          active[NUM_SLOTS];
    logic [7:0]  prio[NUM_SLOTS];
    logic [31:0] used[NUM_SLOTS];
    logic [31:0] resv[NUM_SLOTS];
    logic [31:0] last_sec;
    logic [31:0] total_quota;
    logic [15:0] least_grant;
    grant_t      pending[$];
    int          errors;

    function new();
      foreach (active[i]) begin
        active[i] = 0;
        prio[i]   = '0;
        used[i]   = '0;
        resv[i]   = '0;
      end
      last_sec    = '0;
      total_quota = '0;
      least_grant = MIN_RESERVE_RST;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_TOTAL_QUOTA) total_quota = data;
      else least_grant = data[15:0];
    endfunction

    // Walk the clients by rank and queue one grant report per active client.
    function void run_tick(logic [31:0] now);
      int          order[NUM_SLOTS];
      logic        thr[NUM_SLOTS];
      int          n, rank, s;
      logic [63:0] left, g, u, share, sum;
      grant_t      r;
      if (now == last_sec) return;
      last_sec = now;
      n = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!active[i]) continue;
        rank = 0;
        for (int j = 0; j < NUM_SLOTS; j++)
          if (active[j] && j != i &&
              (prio[j] > prio[i] || (prio[j] == prio[i] && j < i))) rank++;
        order[rank] = i;
        n++;
      end
      left = {32'd0, total_quota};
      for (int k = 0; k < n; k++) begin
        s = order[k];
        u = {32'd0, used[s]};
        g = '0;
        if (left != 0) g = (used[s] == resv[s]) ? (u * 3) / 2 : (u * 11) / 10;
        if (g > left) g = left;
        if (g < {48'd0, least_grant}) g = {48'd0, least_grant};
        left -= (g < left) ? g : left;
        used[s] = '0;
        resv[s] = g[31:0];
        thr[k]  = (left == 0);
      end
      if (left != 0 && n != 0) begin
        share = left / n;
        for (int k = 0; k < n; k++) begin
          sum = {32'd0, resv[order[k]]} + share;
          resv[order[k]] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
      for (int k = 0; k < n; k++) begin
        r.slot = order[k][3:0];
        r.resv = resv[order[k]];
        r.thr  = thr[k];
        r.last = (k == n - 1);
        pending = {pending, r};
      end
    endfunction

    function void note_request(logic [2:0] mode, logic [3:0] slot, logic [7:0] p,
                               logic [31:0] amount, logic [31:0] now);
      logic [32:0] sum;
      case (mode)
        MODE_ATTACH: begin
          active[slot] = 1;
          prio[slot]   = p;
          used[slot]   = '0;
          resv[slot]   = '0;
        end
        MODE_DETACH: active[slot] = 0;
        MODE_PRIO:   prio[slot] = p;
        MODE_USAGE: begin
          sum = {1'b0, used[slot]} + {1'b0, amount};
          used[slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        MODE_TICK:   run_tick(now);
        default: ;
      endcase
    endfunction

    function void check_grant(logic [3:0] slot, logic [31:0] rb, logic thr, logic last);
      grant_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result slot=%0d resv=%0d", $time, slot, rb);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (slot !== e.slot || rb !== e.resv || thr !== e.thr || last !== e.last) begin
        $display("%0t: mismatch exp slot=%0d resv=%0d thr=%0b last=%0b", $time,
                 e.slot, e.resv, e.thr, e.last);
        $display("%0t:          act slot=%0d resv=%0d thr=%0b last=%0b", $time,
                 slot, rb, thr, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [2:0]           mode_i = MODE_ATTACH;
  logic [3:0]           slot_i = '0;
  logic [7:0]           prio_i = '0;
  logic [31:0]          amount_i = '0;
  logic [31:0]          now_seconds_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_TOTAL_QUOTA;
  logic [31:0]          cfg_data_i = '0;
  logic                 strobe_o;
  logic [3:0]           client_slot_o;
  logic [31:0]          reserved_bytes_o;
  logic                 throttled_o;
  logic                 last_o;

  quota_board board = new();
  int         idle_pct;
  int         cycles;
  logic [31:0] clock_sec;

  priority_bandwidth_quota_allocator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Observe handshakes on the edge: feed requests, config writes and results
  // to the scoreboard with the values that were stable during the cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (start && !busy)
        board.note_request(mode_i, slot_i, prio_i, amount_i, now_seconds_i);
      if (strobe_o)
        board.check_grant(client_slot_o, reserved_bytes_o, throttled_o, last_o);
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Hold one request until the block takes it; leave start high so the next
  // request can follow back to back, or, at random, drop start and idle first.
  task automatic send(logic [2:0] mode, logic [3:0] slot, logic [7:0] p,
                      logic [31:0] amount, logic [31:0] now);
    start         <= 1'b1;
    mode_i        <= mode;
    slot_i        <= slot;
    prio_i        <= p;
    amount_i      <= amount;
    now_seconds_i <= now;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every grant report is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic tick();
    clock_sec = clock_sec + 1;
    send(MODE_TICK, 4'($urandom), 8'($urandom), $urandom, clock_sec);
  endtask

  // Random request mix: mostly usage and ticks on a moving second, some table
  // churn, repeated seconds and the odd invalid mode.
  task automatic random_request();
    int          pick;
    logic [3:0]  s;
    logic [31:0] amt;
    pick = $urandom_range(99);
    s    = 4'($urandom);
    if (pick < 14) send(MODE_ATTACH, s, 8'($urandom), $urandom, $urandom);
    else if (pick < 21) send(MODE_DETACH, s, 8'($urandom), $urandom, $urandom);
    else if (pick < 30) send(MODE_PRIO, s, 8'($urandom), $urandom, $urandom);
    else if (pick < 70) begin
      case ($urandom_range(3))
        0: amt = $urandom_range(5000);
        1: amt = $urandom;
        2: amt = 32'hFFFF_FFFF;
        default: amt = board.resv[s] - board.used[s];
      endcase
      send(MODE_USAGE, s, 8'($urandom), amt, $urandom);
    end
    else if (pick < 88) tick();
    else if (pick < 93) send(MODE_TICK, s, 8'($urandom), $urandom, board.last_sec);
    else if (pick < 96) begin
      clock_sec = $urandom;
      send(MODE_TICK, s, 8'($urandom), $urandom, clock_sec);
    end
    else send(3'($urandom_range(MODE_BAD_LO, 7)), s, 8'($urandom), $urandom, $urandom);
  endtask

  initial begin
    logic [31:0] quota_set[5];
    logic [15:0] floor_set[5];
    int          idle_set[5];
    clock_sec = 0;
    idle_pct  = 0;
    quota_set = '{32'd1000, 32'hFFFF_FFFF, 32'd0, 32'd50000, 32'd0};
    floor_set = '{16'd32, 16'd0, 16'hFFFF, 16'd100, 16'd0};
    idle_set  = '{0, 87, 30, 87, 0};
    quota_set[4] = $urandom;
    floor_set[4] = 16'($urandom);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: same-second tick at reset, empty tick, ties, saturation,
    // idle-slot updates, invalid modes, re-attach of a live slot.
    write_reg(CFG_TOTAL_QUOTA, 32'd1000);
    send(MODE_TICK, 4'd0, 8'd0, 32'd0, 32'd0);
    send(MODE_TICK, 4'd0, 8'd0, 32'd0, 32'd5);
    send(MODE_ATTACH, 4'd0, 8'd0, 32'd0, 32'd0);
    send(MODE_ATTACH, 4'd15, 8'd255, 32'd0, 32'd0);
    send(MODE_ATTACH, 4'd7, 8'd255, 32'd0, 32'd0);
    send(MODE_USAGE, 4'd0, 8'd0, 32'hFFFF_FFFF, 32'd0);
    send(MODE_USAGE, 4'd0, 8'd0, 32'hFFFF_FFFF, 32'd0);
    send(MODE_USAGE, 4'd7, 8'd0, 32'd200, 32'd0);
    send(MODE_PRIO, 4'd0, 8'd128, 32'd0, 32'd0);
    send(MODE_DETACH, 4'd3, 8'd0, 32'd0, 32'd0);
    send(MODE_USAGE, 4'd4, 8'd0, 32'd77, 32'd0);
    send(MODE_PRIO, 4'd5, 8'd9, 32'd0, 32'd0);
    send(MODE_BAD_LO, 4'd1, 8'd1, 32'd1, 32'd1);
    send(3'd7, 4'd1, 8'd1, 32'd1, 32'd1);
    clock_sec = 6;
    send(MODE_TICK, 4'd0, 8'd0, 32'd0, clock_sec);
    send(MODE_TICK, 4'd0, 8'd0, 32'd0, clock_sec);
    send(MODE_USAGE, 4'd15, 8'd0, board.resv[15], 32'd0);
    send(MODE_ATTACH, 4'd15, 8'd3, 32'd0, 32'd0);
    send(MODE_ATTACH, 4'd4, 8'd3, 32'd0, 32'd0);
    tick();
    send(MODE_DETACH, 4'd7, 8'd0, 32'd0, 32'd0);
    tick();
    send(MODE_TICK, 4'd0, 8'd0, 32'd0, 32'hFFFF_FFFF);
    clock_sec = 32'hFFFF_FFFF;
    drain();

    // Random phases, each under its own quota setting and idle pattern.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_TOTAL_QUOTA, quota_set[ph]);
      write_reg(CFG_MIN_RESERVE, {16'd0, floor_set[ph]});
      idle_pct = idle_set[ph];
      for (int n = 0; n < 70; n++) random_request();
      drain();
    end

    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/pbqa_pkg.sv
design/pbqa_cell.sv
design/pbqa_div.sv
design/priority_bandwidth_quota_allocator.sv
design/pbqa_chk.sv
sim/tb.sv
